// ----- hdl/quoted_token_lexer_defines.svh -----
// Assertion macros for the quoted token lexer.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef QUOTED_TOKEN_LEXER_DEFINES_SVH
`define QUOTED_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication.
`define QTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define QTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/qtl_pkg.sv -----
// Shared types and character constants for the quoted token lexer.
// No dependencies.
package qtl_pkg;

    // Lexer mode, one-hot.
    typedef enum logic [3:0] {
        MODE_BETWEEN = 4'b0001,
        MODE_PLAIN   = 4'b0010,
        MODE_QUOTED  = 4'b0100,
        MODE_ESCAPE  = 4'b1000
    } t_lex_mode;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Whitespace as isspace sees it: space and 0x09 to 0x0D.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ----- hdl/quoted_token_lexer.sv -----
// Quoted token lexer: one request per cycle sustained while the result
// channel does not stall; lexer state updates as a request moves on to the
// result register. Input and result registers bracket the decode logic, so
// an empty input register takes a new request while a result is stalled.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// lexer to the between-tokens mode with no quote and no pending token.
// Depends on qtl_pkg and quoted_token_lexer_defines.svh.
`include "quoted_token_lexer_defines.svh"

module quoted_token_lexer import qtl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_of_line,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_char_valid,
    output logic [7:0] o_out_char,
    output logic       o_token_end,
    output logic       o_line_end
);

    // ---------------------------------------------------------------
    // Pipeline control. The result register can load when it is empty
    // or its content leaves this cycle; the input register then moves
    // its request forward and may take a new one in the same edge.
    // ---------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       r_out_valid;
    logic       r_char_valid;
    logic [7:0] r_out_char;
    logic       r_token_end;
    logic       r_line_end;

    logic out_ready;
    logic s1_fire;
    logic in_fire;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_fire    = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Lexer state: mode, kind of the open quote, and whether the open
    // token has produced any character yet.
    // ---------------------------------------------------------------
    t_lex_mode r_mode, n_mode;
    logic      r_quote_dbl, n_quote_dbl;
    logic      r_tok_chars, n_tok_chars;

    // Per-byte decode before end-of-line handling.
    t_lex_mode  c_mode;
    logic       c_quote_dbl;
    logic       c_tok_chars;
    logic       c_valid;
    logic [7:0] c_char;
    logic       c_tend;
    logic [7:0] quote_ch;
    logic       blank;

    logic       n_char_valid;
    logic [7:0] n_out_char;
    logic       n_token_end;

    assign quote_ch = r_quote_dbl ? CH_DQUOTE : CH_SQUOTE;
    assign blank    = is_blank(r_in_byte);

    always_comb begin
        c_mode      = r_mode;
        c_quote_dbl = r_quote_dbl;
        c_tok_chars = r_tok_chars;
        c_valid     = 1'b0;
        c_char      = 8'h00;
        c_tend      = 1'b0;
        unique case (r_mode)
            MODE_BETWEEN: begin
                if (!blank) begin
                    if (r_in_byte == CH_SQUOTE || r_in_byte == CH_DQUOTE) begin
                        // opening quote: token starts empty
                        c_quote_dbl = (r_in_byte == CH_DQUOTE);
                        c_tok_chars = 1'b0;
                        c_mode      = MODE_QUOTED;
                    end else begin
                        c_valid     = 1'b1;
                        c_char      = r_in_byte;
                        c_tok_chars = 1'b1;
                        c_mode      = MODE_PLAIN;
                    end
                end
            end
            MODE_PLAIN: begin
                if (blank) begin
                    c_tend      = r_tok_chars;
                    c_tok_chars = 1'b0;
                    c_mode      = MODE_BETWEEN;
                end else begin
                    c_valid     = 1'b1;
                    c_char      = r_in_byte;
                    c_tok_chars = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (r_in_byte == quote_ch) begin
                    // closing quote; empty quoted token gives no token end
                    c_tend      = r_tok_chars;
                    c_tok_chars = 1'b0;
                    c_mode      = MODE_BETWEEN;
                end else if (r_in_byte == CH_BSLASH && !r_in_last) begin
                    c_mode = MODE_ESCAPE;
                end else begin
                    // includes a backslash on the last byte, kept literal
                    c_valid     = 1'b1;
                    c_char      = r_in_byte;
                    c_tok_chars = 1'b1;
                end
            end
            MODE_ESCAPE: begin
                c_valid = 1'b1;
                if (r_in_byte == CH_N) begin
                    c_char = CH_LF;
                end else if (r_in_byte == CH_T) begin
                    c_char = CH_TAB;
                end else begin
                    c_char = r_in_byte;
                end
                c_tok_chars = 1'b1;
                c_mode      = MODE_QUOTED;
            end
            default: begin
                c_mode = MODE_BETWEEN;
            end
        endcase
    end

    // End of line closes any open token that holds characters (an
    // unclosed quote too) and returns every state bit to reset.
    always_comb begin
        n_char_valid = c_valid;
        n_out_char   = c_char;
        n_token_end  = c_tend;
        n_mode       = c_mode;
        n_quote_dbl  = c_quote_dbl;
        n_tok_chars  = c_tok_chars;
        if (r_in_last) begin
            if (c_mode != MODE_BETWEEN && c_tok_chars) begin
                n_token_end = 1'b1;
            end
            n_mode      = MODE_BETWEEN;
            n_quote_dbl = 1'b0;
            n_tok_chars = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_BETWEEN;
            r_quote_dbl <= 1'b0;
            r_tok_chars <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (s1_fire) begin
                r_mode      <= n_mode;
                r_quote_dbl <= n_quote_dbl;
                r_tok_chars <= n_tok_chars;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_of_line;
        end
        if (s1_fire) begin
            r_char_valid <= n_char_valid;
            r_out_char   <= n_out_char;
            r_token_end  <= n_token_end;
            r_line_end   <= r_in_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_valid = r_char_valid;
    assign o_out_char   = r_out_char;
    assign o_token_end  = r_token_end;
    assign o_line_end   = r_line_end;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `QTL_ASSERT_NOW(a_char_zero, o_out_valid && !o_char_valid, o_out_char == 8'h00,
        "out_char not zero without a character")
    `QTL_ASSERT_NEXT(a_line_reset, s1_fire && r_in_last,
        r_mode == MODE_BETWEEN && !r_tok_chars && !r_quote_dbl,
        "lexer state not cleared after end of line")
    `QTL_ASSERT_NOW(a_between_empty, r_mode == MODE_BETWEEN, !r_tok_chars,
        "pending token characters between tokens")
    `QTL_ASSERT_NOW(a_plain_chars, r_mode == MODE_PLAIN, r_tok_chars,
        "unquoted token without characters")

endmodule
